>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL in this folder.
// No dependencies; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

>>> rtl/core/segscan_pkg.sv
// Package for the four-digit segment display scanner: op codes, constants,
// segment font and small arithmetic helpers. No dependencies.
package segscan_pkg;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_NUMBER = 2'd1,
    OP_TIME   = 2'd2,
    OP_POINT  = 2'd3
  } op_t;

  // floor(n / 10000) = (n * DIV10K_MAGIC) >> DIV10K_SHIFT for any 32-bit n
  localparam logic [31:0] DIV10K_MAGIC = 32'd3518437209;
  localparam int          DIV10K_SHIFT = 45;
  localparam logic [13:0] TEN_THOUSAND = 14'd10000;

  // Reciprocals for values below 10000
  localparam logic [12:0] DIV10_MAGIC   = 13'd6554;  // >> 16
  localparam logic [12:0] DIV100_MAGIC  = 13'd5243;  // >> 19
  localparam logic [13:0] DIV1000_MAGIC = 14'd8389;  // >> 23

  localparam logic [6:0] HUNDRED = 7'd100;

  // Active-low font, bit 7 (point) high
  function automatic logic [7:0] seg_font(input logic [3:0] d);
    logic [7:0] f;
    case (d)
      4'd0:    f = 8'hC0;
      4'd1:    f = 8'hF9;
      4'd2:    f = 8'hA4;
      4'd3:    f = 8'hB0;
      4'd4:    f = 8'h99;
      4'd5:    f = 8'h92;
      4'd6:    f = 8'h82;
      4'd7:    f = 8'hF8;
      4'd8:    f = 8'h80;
      4'd9:    f = 8'h90;
      default: f = 8'hFF;
    endcase
    return f;
  endfunction

  // 8-bit value modulo 60: parallel compares, one subtract
  function automatic logic [5:0] mod60(input logic [7:0] v);
    logic [7:0] sub;
    if (v >= 8'd240)      sub = 8'd240;
    else if (v >= 8'd180) sub = 8'd180;
    else if (v >= 8'd120) sub = 8'd120;
    else if (v >= 8'd60)  sub = 8'd60;
    else                  sub = 8'd0;
    return 6'(v - sub);
  endfunction

endpackage

>>> rtl/core/four_digit_segment_display_scanner.sv
// Four-digit segment display scanner, top level.
// Depends on segscan_pkg and assert_macros.svh.
//
// Takes one transaction per cycle. Op 1 stores a number modulo 10000, op 2
// stores minutes*100+seconds (each modulo 60) and lights only the point of
// digit 2, op 3 sets or clears one digit's point, op 0 is a scan tick that
// steps to the next digit and returns its active-low segments and
// active-low one-cold digit enable. Every transaction runs through a
// four-stage pipeline (the mod-10000 reduction needs a 32x32 reciprocal
// multiply and a back-multiply, then a digit split) and takes effect in
// order at the last stage, so a tick always sees every earlier setting.
// A tick result passes through stages 1 to 4 and then the output register;
// throughput is one transaction per cycle as long as results are taken.
// Non-tick transactions produce no result.
`include "assert_macros.svh"

module four_digit_segment_display_scanner (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [31:0] number,
  input  logic [7:0]  minute,
  input  logic [7:0]  second,
  input  logic [2:0]  digit_sel,
  input  logic        point_on,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  segments,
  output logic [3:0]  digit_enable
);

  // ---------------- stage 1: input register ----------------
  logic               s1_valid;
  segscan_pkg::op_t   s1_op;
  logic [31:0]        s1_number;
  logic [7:0]         s1_minute;
  logic [7:0]         s1_second;
  logic [2:0]         s1_dsel;
  logic               s1_pon;

  // ---------------- stage 2 ----------------
  logic               s2_valid;
  segscan_pkg::op_t   s2_op;
  logic [18:0]        s2_quot;
  logic [13:0]        s2_nlow;
  logic [12:0]        s2_time;
  logic [2:0]         s2_dsel;
  logic               s2_pon;

  // ---------------- stage 3 ----------------
  logic               s3_valid;
  segscan_pkg::op_t   s3_op;
  logic [13:0]        s3_value;
  logic [2:0]         s3_dsel;
  logic               s3_pon;

  // ---------------- stage 4 ----------------
  logic               s4_valid;
  segscan_pkg::op_t   s4_op;
  logic [13:0]        s4_value;
  logic [9:0]         s4_div10;
  logic [6:0]         s4_div100;
  logic [3:0]         s4_div1000;
  logic [2:0]         s4_dsel;
  logic               s4_pon;

  // ---------------- display state ----------------
  logic [3:0]         digit [4];
  logic [3:0]         point_mask;
  logic [1:0]         scan_pos;

  // ---------------- flow control ----------------
  logic out_ready, rdy1, rdy2, rdy3, rdy4, commit, tick_fire;

  assign out_ready = !out_valid || !out_stall;
  assign tick_fire = s4_valid && (s4_op == segscan_pkg::OP_TICK);
  assign rdy4      = !s4_valid || (s4_op != segscan_pkg::OP_TICK) || out_ready;
  assign rdy3      = !s3_valid || rdy4;
  assign rdy2      = !s2_valid || rdy3;
  assign rdy1      = !s1_valid || rdy2;
  assign commit    = s4_valid && rdy4;
  assign in_stall  = !rdy1;

  // ---------------- stage 1 logic ----------------
  logic [63:0] quot_prod;
  logic [5:0]  min_mod, sec_mod;
  logic [12:0] time_val;

  assign quot_prod = 64'(s1_number) * 64'(segscan_pkg::DIV10K_MAGIC);
  assign min_mod   = segscan_pkg::mod60(s1_minute);
  assign sec_mod   = segscan_pkg::mod60(s1_second);
  assign time_val  = 13'(13'(min_mod) * 13'(segscan_pkg::HUNDRED)) + 13'(sec_mod);

  // ---------------- stage 2 logic ----------------
  logic [27:0] back_prod;
  logic [13:0] rem_val;

  // only the low 14 bits matter: the remainder is below 2^14
  assign back_prod = 28'(s2_quot[13:0]) * 28'(segscan_pkg::TEN_THOUSAND);
  assign rem_val   = s2_nlow - back_prod[13:0];

  // ---------------- stage 3 logic ----------------
  logic [26:0] p10, p100;
  logic [27:0] p1000;

  assign p10   = 27'(s3_value) * 27'(segscan_pkg::DIV10_MAGIC);
  assign p100  = 27'(s3_value) * 27'(segscan_pkg::DIV100_MAGIC);
  assign p1000 = 28'(s3_value) * 28'(segscan_pkg::DIV1000_MAGIC);

  // ---------------- stage 4 logic ----------------
  logic [13:0] d0_full;
  logic [9:0]  d1_full;
  logic [6:0]  d2_full;
  logic [1:0]  pos_next;
  logic [7:0]  seg_next;

  assign d0_full  = s4_value - 14'(14'(s4_div10) * 14'd10);
  assign d1_full  = s4_div10 - 10'(10'(s4_div100) * 10'd10);
  assign d2_full  = s4_div100 - 7'(7'(s4_div1000) * 7'd10);
  assign pos_next = scan_pos + 2'd1;

  always_comb begin
    seg_next    = segscan_pkg::seg_font(digit[pos_next]);
    seg_next[7] = ~point_mask[pos_next];
  end

  // ---------------- pipeline registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      if (rdy1) s1_valid <= in_valid;
      if (rdy2) s2_valid <= s1_valid;
      if (rdy3) s3_valid <= s2_valid;
      if (rdy4) s4_valid <= s3_valid;
    end

    if (rdy1 && in_valid) begin
      s1_op     <= segscan_pkg::op_t'(op);
      s1_number <= number;
      s1_minute <= minute;
      s1_second <= second;
      s1_dsel   <= digit_sel;
      s1_pon    <= point_on;
    end
    if (rdy2 && s1_valid) begin
      s2_op   <= s1_op;
      s2_quot <= quot_prod[63:segscan_pkg::DIV10K_SHIFT];
      s2_nlow <= s1_number[13:0];
      s2_time <= time_val;
      s2_dsel <= s1_dsel;
      s2_pon  <= s1_pon;
    end
    if (rdy3 && s2_valid) begin
      s3_op    <= s2_op;
      s3_value <= (s2_op == segscan_pkg::OP_TIME) ? 14'(s2_time) : rem_val;
      s3_dsel  <= s2_dsel;
      s3_pon   <= s2_pon;
    end
    if (rdy4 && s3_valid) begin
      s4_op      <= s3_op;
      s4_value   <= s3_value;
      s4_div10   <= p10[25:16];
      s4_div100  <= p100[25:19];
      s4_div1000 <= p1000[26:23];
      s4_dsel    <= s3_dsel;
      s4_pon     <= s3_pon;
    end
  end

  // ---------------- state commit and output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      digit[0]   <= 4'd0;
      digit[1]   <= 4'd0;
      digit[2]   <= 4'd0;
      digit[3]   <= 4'd0;
      point_mask <= 4'd0;
      scan_pos   <= 2'd3;
      out_valid  <= 1'b0;
    end else begin
      if (out_ready) out_valid <= tick_fire;
      if (commit) begin
        unique case (s4_op)
          segscan_pkg::OP_TICK: begin
            scan_pos <= pos_next;
          end
          segscan_pkg::OP_NUMBER: begin
            digit[0] <= d0_full[3:0];
            digit[1] <= d1_full[3:0];
            digit[2] <= d2_full[3:0];
            digit[3] <= s4_div1000;
          end
          segscan_pkg::OP_TIME: begin
            digit[0]   <= d0_full[3:0];
            digit[1]   <= d1_full[3:0];
            digit[2]   <= d2_full[3:0];
            digit[3]   <= s4_div1000;
            point_mask <= 4'b0100;
          end
          segscan_pkg::OP_POINT: begin
            if (!s4_dsel[2]) point_mask[s4_dsel[1:0]] <= s4_pon;
          end
          default: begin
          end
        endcase
      end
    end
    if (tick_fire && out_ready) begin
      segments     <= seg_next;
      digit_enable <= ~(4'b0001 << pos_next);
    end
  end

  // ---------------- assertions ----------------
  `ASSERT_IMPL(a_enable_one_cold, clk, rst, out_valid, $onehot(~digit_enable),
               "digit enable is not one-cold")
  `ASSERT_IMPL(a_digits_bcd, clk, rst, 1'b1,
               (digit[0] <= 4'd9) && (digit[1] <= 4'd9) && (digit[2] <= 4'd9) &&
               (digit[3] <= 4'd9), "stored digit out of range")
  `ASSERT_NEXT(a_tick_to_output, clk, rst, tick_fire && out_ready,
               out_valid && (digit_enable == ~(4'b0001 << scan_pos)),
               "tick result not registered at the new position")
  `ASSERT_NEXT(a_blocked_tick_holds, clk, rst, tick_fire && !out_ready,
               s4_valid && (s4_op == segscan_pkg::OP_TICK) && $stable(scan_pos),
               "blocked tick left the last stage")

endmodule
